// File: rtl/boot_phase_bus_monitor_macros.svh
// Assertion helpers for the boot phase bus monitor.
`ifndef BOOT_PHASE_BUS_MONITOR_MACROS_SVH
`define BOOT_PHASE_BUS_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BPBM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BPBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bpbm_pkg.sv
`default_nettype none
package bpbm_pkg;

  localparam int NumPhases = 9;

  // event kinds
  localparam logic [2:0] ActFetch = 3'd0;
  localparam logic [2:0] ActMemRd = 3'd1;
  localparam logic [2:0] ActMemWr = 3'd2;
  localparam logic [2:0] ActIoWr  = 3'd3;

  // phase bit positions
  localparam int PhResetVec  = 0;
  localparam int PhBiosEarly = 1;
  localparam int PhSlotProbe = 2;
  localparam int PhBiosDone  = 3;
  localparam int PhHandoff   = 4;
  localparam int PhColdstart = 5;
  localparam int PhBasicVecs = 6;
  localparam int PhVdp       = 7;
  localparam int PhCart      = 8;

  // fetch landmarks
  localparam logic [15:0] AddrResetVec  = 16'h0000;
  localparam logic [15:0] AddrBiosEarly = 16'h02D7;
  localparam logic [15:0] AddrBiosDone  = 16'h03F8;
  localparam logic [15:0] AddrHandoff   = 16'h2680;
  localparam logic [15:0] AddrColdstart = 16'h7C76;
  localparam logic [15:0] AddrVec0      = 16'h003B;
  localparam logic [15:0] AddrVec1      = 16'h003E;
  localparam logic [15:0] AddrVec2      = 16'h0069;
  localparam logic [15:0] AddrVec3      = 16'h006F;
  localparam logic [15:0] AddrCartScan  = 16'h7D75;

  // memory landmarks
  localparam logic [15:0] AddrHdrFirst  = 16'h4000;
  localparam logic [15:0] AddrHdrSecond = 16'h4001;
  localparam logic [15:0] AddrWorkArea  = 16'hFD9A;
  localparam logic [15:0] AddrTop       = 16'hFFFF;
  localparam logic [15:0] AddrBf00      = 16'hBF00;
  localparam logic [15:0] AddrFe00      = 16'hFE00;
  localparam logic [15:0] AddrHighRam   = 16'hC000;

  // I/O ports
  localparam logic [7:0] PortSlotSel = 8'hA8;
  localparam logic [7:0] PortPpiC    = 8'hAA;
  localparam logic [7:0] PortPpiCtl  = 8'hAB;
  localparam logic [7:0] PortVdpData = 8'h98;
  localparam logic [7:0] PortVdpCtl  = 8'h99;

  // header signature
  localparam logic [7:0] HdrByteA = 8'h41;
  localparam logic [7:0] HdrByteB = 8'h42;
  localparam logic [7:0] HdrReset = 8'hFF;

  localparam logic [4:0] LastNone    = 5'h1F;
  localparam logic [3:0] AreaNone    = 4'd0;
  localparam logic [3:0] AreaCartHdr = 4'd10;

  typedef logic [NumPhases-1:0] phase_mask_t;

  // decoded effect of one bus event
  typedef struct packed {
    phase_mask_t phase_set;
    logic        ppi_set;
    logic        wa_set;
    logic        hdr_first_ld;
    logic        hdr_second_ld;
  } evt_t;

  // result word, phase_bits in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [3:0]  failure_area;
    logic [7:0]  header_second;
    logic [7:0]  header_first;
    logic        header_ok;
    logic        workarea_seen;
    logic        ppi_seen;
    logic [3:0]  next_missing;
    logic [4:0]  last_phase;
    phase_mask_t phase_bits;
  } result_t;

  function automatic logic [4:0] highest_phase(phase_mask_t m);
    logic [4:0] r;
    r = LastNone;
    for (int i = 0; i < NumPhases; i++) begin
      if (m[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] lowest_missing(phase_mask_t m);
    logic [3:0] r;
    r = 4'(NumPhases);
    for (int i = NumPhases - 1; i >= 0; i--) begin
      if (!m[i]) r = 4'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bpbm_decode.sv
`default_nettype none
// Landmark match: turns one registered bus event into set/load strobes.
module bpbm_decode (
  input  wire logic [2:0]     action,
  input  wire logic [15:0]    address,
  input  wire logic           byte_ok,
  output bpbm_pkg::evt_t      evt
);

  logic [7:0] port;

  assign port = address[7:0];

  always_comb begin
    evt = '0;
    case (action)
      bpbm_pkg::ActFetch: begin
        if (address == bpbm_pkg::AddrResetVec)  evt.phase_set[bpbm_pkg::PhResetVec]  = 1'b1;
        if (address == bpbm_pkg::AddrBiosEarly) evt.phase_set[bpbm_pkg::PhBiosEarly] = 1'b1;
        if (address == bpbm_pkg::AddrBiosDone)  evt.phase_set[bpbm_pkg::PhBiosDone]  = 1'b1;
        if (address == bpbm_pkg::AddrHandoff)   evt.phase_set[bpbm_pkg::PhHandoff]   = 1'b1;
        if (address == bpbm_pkg::AddrColdstart) evt.phase_set[bpbm_pkg::PhColdstart] = 1'b1;
        if (address == bpbm_pkg::AddrVec0 || address == bpbm_pkg::AddrVec1 ||
            address == bpbm_pkg::AddrVec2 || address == bpbm_pkg::AddrVec3)
          evt.phase_set[bpbm_pkg::PhBasicVecs] = 1'b1;
        if (address == bpbm_pkg::AddrCartScan)  evt.phase_set[bpbm_pkg::PhCart]      = 1'b1;
      end
      bpbm_pkg::ActMemRd: begin
        if (address == bpbm_pkg::AddrHdrFirst || address == bpbm_pkg::AddrHdrSecond)
          evt.phase_set[bpbm_pkg::PhCart] = 1'b1;
        evt.hdr_first_ld  = byte_ok && (address == bpbm_pkg::AddrHdrFirst);
        evt.hdr_second_ld = byte_ok && (address == bpbm_pkg::AddrHdrSecond);
      end
      bpbm_pkg::ActMemWr: begin
        if (address == bpbm_pkg::AddrWorkArea) begin
          evt.wa_set                            = 1'b1;
          evt.phase_set[bpbm_pkg::PhColdstart] = 1'b1;
        end
        if (address == bpbm_pkg::AddrTop || address == bpbm_pkg::AddrBf00 ||
            address == bpbm_pkg::AddrFe00 || address >= bpbm_pkg::AddrHighRam)
          evt.phase_set[bpbm_pkg::PhSlotProbe] = 1'b1;
      end
      bpbm_pkg::ActIoWr: begin
        if (port == bpbm_pkg::PortPpiCtl || port == bpbm_pkg::PortSlotSel ||
            port == bpbm_pkg::PortPpiC) begin
          evt.ppi_set                           = 1'b1;
          evt.phase_set[bpbm_pkg::PhBiosEarly] = 1'b1;
          if (port == bpbm_pkg::PortSlotSel)
            evt.phase_set[bpbm_pkg::PhSlotProbe] = 1'b1;
        end else if (port == bpbm_pkg::PortVdpCtl || port == bpbm_pkg::PortVdpData) begin
          evt.phase_set[bpbm_pkg::PhVdp] = 1'b1;
        end
      end
      default: begin
        evt = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/bpbm_track.sv
`default_nettype none
// Sticky boot state plus the result register; both load on the same edge.
module bpbm_track (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire bpbm_pkg::evt_t  evt,
  input  wire logic [7:0]      data_byte,
  output bpbm_pkg::result_t    res
);

  bpbm_pkg::phase_mask_t phase_r, phase_nxt;
  logic                  ppi_r, ppi_nxt;
  logic                  wa_r, wa_nxt;
  logic                  hok_r, hok_nxt;
  logic [7:0]            hfirst_r, hfirst_nxt;
  logic [7:0]            hsecond_r, hsecond_nxt;
  bpbm_pkg::result_t     res_r, res_nxt;
  logic [4:0]            last;

  always_comb begin
    phase_nxt   = phase_r | evt.phase_set;
    ppi_nxt     = ppi_r | evt.ppi_set;
    wa_nxt      = wa_r | evt.wa_set;
    hfirst_nxt  = evt.hdr_first_ld  ? data_byte : hfirst_r;
    hsecond_nxt = evt.hdr_second_ld ? data_byte : hsecond_r;
    hok_nxt     = hok_r ||
                  ((evt.hdr_first_ld || evt.hdr_second_ld) &&
                   hfirst_nxt == bpbm_pkg::HdrByteA && hsecond_nxt == bpbm_pkg::HdrByteB);
    last        = bpbm_pkg::highest_phase(phase_nxt);

    res_nxt               = '0;
    res_nxt.phase_bits    = phase_nxt;
    res_nxt.last_phase    = last;
    res_nxt.next_missing  = bpbm_pkg::lowest_missing(phase_nxt);
    res_nxt.ppi_seen      = ppi_nxt;
    res_nxt.workarea_seen = wa_nxt;
    res_nxt.header_ok     = hok_nxt;
    res_nxt.header_first  = hfirst_nxt;
    res_nxt.header_second = hsecond_nxt;
    if (last == bpbm_pkg::LastNone) begin
      res_nxt.failure_area = bpbm_pkg::AreaNone;
    end else if (last == 5'(bpbm_pkg::PhCart) && hok_nxt) begin
      res_nxt.failure_area = bpbm_pkg::AreaCartHdr;
    end else begin
      res_nxt.failure_area = last[3:0] + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      ppi_r     <= 1'b0;
      wa_r      <= 1'b0;
      hok_r     <= 1'b0;
      hfirst_r  <= bpbm_pkg::HdrReset;
      hsecond_r <= bpbm_pkg::HdrReset;
    end else if (load) begin
      phase_r   <= phase_nxt;
      ppi_r     <= ppi_nxt;
      wa_r      <= wa_nxt;
      hok_r     <= hok_nxt;
      hfirst_r  <= hfirst_nxt;
      hsecond_r <= hsecond_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// File: rtl/boot_phase_bus_monitor.sv
// Boot phase bus monitor: watches a stream of bus events and reports boot progress.
// Input channel (in_*): one bus event per transfer. in_tuser carries the event kind
//   and the byte-ok flag, in_tdata the address and the data byte.
// Output channel (out_*): one result per event, taken after that event is applied:
//   sticky phase bits, highest seen phase, lowest missing phase, the PPI, work-area
//   and header flags, both latched header bytes and the failure-area code.
// Path: an accepted event is held in the event register, then the state update and
//   result register load in one pass; out_tvalid rises once the result is registered.
// Throughput: one event per clock; the pipeline is two registers deep, gated only
//   by out_tready.
// Stall: when out_tready is low the result holds and the event register fills; one
//   more event is taken, then in_tready drops until the result is taken.
// Reset (rst_n low, synchronous): both stages empty, phases and flags clear,
//   header bytes back to FFh.
`default_nettype none
module boot_phase_bus_monitor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // address[15:0], data_byte[23:16]
  input  wire logic [3:0]  in_tuser,   // action[2:0], byte_ok[3]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // phase_bits[8:0], last_phase[13:9], next_missing[17:14], ppi_seen[18],
  // workarea_seen[19], header_ok[20], header_first[28:21], header_second[36:29],
  // failure_area[40:37], zero fill [47:41]
  output logic [47:0]      out_tdata
);

  `include "boot_phase_bus_monitor_macros.svh"

  // stage 1: registered event
  logic        ev_valid_r;
  logic [2:0]  ev_action_r;
  logic [15:0] ev_addr_r;
  logic [7:0]  ev_data_r;
  logic        ev_dvalid_r;

  // stage 2: result valid (payload lives in the tracker)
  logic        out_valid_r;

  logic        res_free;   // result register can take a new value
  logic        ev_fire;    // event moves into state and result
  logic        in_fire;

  bpbm_pkg::evt_t    evt;
  bpbm_pkg::result_t res;

  assign res_free  = !out_valid_r || out_tready;
  assign ev_fire   = ev_valid_r && res_free;
  assign in_tready = !ev_valid_r || res_free;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        ev_valid_r <= in_tvalid;
      end
      if (res_free) begin
        out_valid_r <= ev_valid_r;
      end
    end
  end

  // event payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_action_r <= in_tuser[2:0];
      ev_dvalid_r <= in_tuser[3];
      ev_addr_r   <= in_tdata[15:0];
      ev_data_r   <= in_tdata[23:16];
    end
  end

  bpbm_decode u_decode (
    .action     (ev_action_r),
    .address    (ev_addr_r),
    .byte_ok    (ev_dvalid_r),
    .evt        (evt)
  );

  bpbm_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ev_fire),
    .evt       (evt),
    .data_byte (ev_data_r),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res;

  // an empty result stage must never block the input
  `BPBM_ASSERT_IMPL(a_ready_when_empty, !out_tvalid, in_tready, "input blocked with empty output")
  // an accepted event lands in the event register
  `BPBM_ASSERT_NEXT(a_event_held, in_tvalid && in_tready, ev_valid_r, "accepted event lost")
  // no phase seen means last_phase reads 1Fh (LastNone), and the reverse
  `BPBM_ASSERT_IMPL(a_last_none, out_tvalid,
    (res.last_phase == bpbm_pkg::LastNone) == (res.phase_bits == '0), "last_phase mismatch")
  // phase bits never clear once reported
  `BPBM_ASSERT_IMPL(a_phase_sticky, $past(out_tvalid) && $past(rst_n),
    (res.phase_bits & $past(res.phase_bits)) == $past(res.phase_bits), "phase bit cleared")

endmodule
`default_nettype wire
